// ===== src/oets_pkg.sv =====
package oets_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_L,
    ST_RD_R,
    ST_CMP,
    ST_WR_L,
    ST_WR_R,
    ST_OUT_RD,
    ST_OUT
  } state_e;

  localparam logic [31:0] ExpMask  = 32'h7F80_0000;
  localparam logic [31:0] ManMask  = 32'h007F_FFFF;
  localparam logic [31:0] MagMask  = 32'h7FFF_FFFF;
  localparam logic [31:0] SignMask = 32'h8000_0000;

  function automatic logic is_nan(logic [31:0] b);
    return ((b & ExpMask) == ExpMask) && ((b & ManMask) != 32'd0);
  endfunction

  function automatic logic [31:0] order_key(logic [31:0] b);
    return b[31] ? ~b : (b | SignMask);
  endfunction

  // IEEE strict greater-than on raw patterns
  function automatic logic fp_greater(logic [31:0] a, logic [31:0] b);
    logic res;
    res = 1'b0;
    if (!is_nan(a) && !is_nan(b) &&
        !(((a & MagMask) == 32'd0) && ((b & MagMask) == 32'd0))) begin
      res = order_key(a) > order_key(b);
    end
    return res;
  endfunction

endpackage

// ===== src/oets_if.sv =====
interface oets_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        end_of_set;
  modport source (output valid, value_bits, end_of_set, input ready);
  modport sink (input valid, value_bits, end_of_set, output ready);
endinterface

interface oets_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sorted_bits;
  logic        last_out;
  logic        overflowed;
  modport source (output valid, sorted_bits, last_out, overflowed, input ready);
  modport sink (input valid, sorted_bits, last_out, overflowed, output ready);
endinterface

// ===== src/oets_cmp.sv =====
// Shared compare-exchange unit: registered swap decision.
module oets_cmp (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] left_i,
  input  logic [31:0] right_i,
  output logic        swap_o
);
  logic swap_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      swap_q <= oets_pkg::fp_greater(left_i, right_i);
    end
  end

  assign swap_o = swap_q;
endmodule

// ===== src/odd_even_transposition_sorter.sv =====
// Load: one beat per cycle. Sort: n phases; each pair passes through
// states to read left, read right, compare and decide, on one shared
// comparator, plus a second write state when it swaps, and each phase
// ends with a step-on state. Emit: a read state, then the output beat,
// held under output stall. Not ready outside loading.
// Reset (async, active low) clears count, overflow flag and sequencer;
// the element store is not cleared (only written entries are read).
module odd_even_transposition_sorter #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oets_in_if.sink    in_if,
  oets_out_if.source out_if
);
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam logic [CW-1:0] Max = CW'(MAX_ELEMENTS);

  oets_pkg::state_e state_q, state_d;

  logic [31:0] mem [MAX_ELEMENTS];
  logic [31:0] rd_q, left_q, right_q;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] phase_q, phase_d;
  logic [CW-1:0] k_q, k_d;        // left index of current pair / out index
  logic          ovf_q, ovf_d;
  logic          swap;
  logic          in_acc, out_acc;

  // memory control
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  assign in_acc  = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  assign in_if.ready = (state_q == oets_pkg::ST_LOAD);
  assign out_if.valid = (state_q == oets_pkg::ST_OUT);
  assign out_if.sorted_bits = rd_q;
  assign out_if.last_out = (k_q + CW'(1) == count_q);
  assign out_if.overflowed = ovf_q;

  // left_q holds mem[k], rd_q holds mem[k+1] during ST_CMP;
  // the swap decision is ready in ST_WR_L
  oets_cmp u_cmp (
    .clk_i  (clk_i),
    .en_i   (state_q == oets_pkg::ST_CMP),
    .left_i (left_q),
    .right_i(rd_q),
    .swap_o (swap)
  );

  // next state and counters
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    phase_d = phase_q;
    k_d     = k_q;
    ovf_d   = ovf_q;
    case (state_q)
      oets_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (count_q < Max) count_d = count_q + CW'(1);
          else ovf_d = 1'b1;
          if (in_if.end_of_set) begin
            phase_d = '0;
            k_d     = '0;
            state_d = oets_pkg::ST_RD_L;
          end
        end
      end
      oets_pkg::ST_RD_L: begin
        // go to output after the last phase; step on when no pair is left
        if (phase_q == count_q) begin
          k_d = '0;
          state_d = oets_pkg::ST_OUT_RD;
        end else if (k_q + CW'(1) >= count_q) begin
          phase_d = phase_q + CW'(1);
          k_d     = {{(CW-1){1'b0}}, ~phase_q[0]};
        end else begin
          state_d = oets_pkg::ST_RD_R;
        end
      end
      oets_pkg::ST_RD_R: state_d = oets_pkg::ST_CMP;
      oets_pkg::ST_CMP:  state_d = oets_pkg::ST_WR_L;
      oets_pkg::ST_WR_L: begin
        state_d = swap ? oets_pkg::ST_WR_R : oets_pkg::ST_RD_L;
        if (!swap) k_d = k_q + CW'(2);
      end
      oets_pkg::ST_WR_R: begin
        k_d = k_q + CW'(2);
        state_d = oets_pkg::ST_RD_L;
      end
      oets_pkg::ST_OUT_RD: state_d = oets_pkg::ST_OUT;
      oets_pkg::ST_OUT: begin
        if (out_acc) begin
          if (k_q + CW'(1) == count_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            k_d     = '0;
            state_d = oets_pkg::ST_LOAD;
          end else begin
            k_d = k_q + CW'(1);
            state_d = oets_pkg::ST_OUT_RD;
          end
        end
      end
      default: state_d = oets_pkg::ST_LOAD;
    endcase
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = k_q[AW-1:0];
    wdata = right_q;
    raddr = k_q[AW-1:0];
    case (state_q)
      oets_pkg::ST_LOAD: begin
        we    = in_acc && (count_q < Max);
        waddr = count_q[AW-1:0];
        wdata = in_if.value_bits;
      end
      oets_pkg::ST_RD_R: raddr = AW'(k_q + CW'(1));
      oets_pkg::ST_WR_L: begin
        // write right value to left slot on swap
        we    = swap;
        waddr = k_q[AW-1:0];
        wdata = right_q;
      end
      oets_pkg::ST_WR_R: begin
        we    = 1'b1;
        waddr = AW'(k_q + CW'(1));
        wdata = left_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
    if (state_q == oets_pkg::ST_RD_R) left_q <= rd_q;
    if (state_q == oets_pkg::ST_CMP) right_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oets_pkg::ST_LOAD;
      count_q <= '0;
      phase_q <= '0;
      k_q     <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      ovf_q   <= ovf_d;
    end
  end
endmodule

// ===== src/oets_checker.sv =====
module oets_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] sorted_bits,
  input logic        last_out
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("in ready during output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(sorted_bits))
    else $error("output beat dropped");

  a_last_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && last_out |=> in_ready)
    else $error("not back to load after last");
endmodule

bind odd_even_transposition_sorter oets_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .sorted_bits(out_if.sorted_bits), .last_out(out_if.last_out)
);
